/* hw/rtl/pna_pkg.sv */
// ----------------------------------------------------------------------------
// pna_pkg: shared types and constants for the polyline normal unit
// Widths of the fixed-format fields, sequencer states and pass codes.
// ----------------------------------------------------------------------------
`default_nettype none
package pna_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int UNIT_W      = 16;
  localparam int COMP_W      = 15;
  localparam int ARC_W       = 32;
  localparam int LEN_W       = 33;
  localparam int MAG_BITS    = 16;
  localparam int SUMS_W      = 33;
  localparam int SQC_W       = 32;
  localparam int FRAC_SHIFT  = 30;
  localparam int DIV_NUM_W   = SQC_W + FRAC_SHIFT;
  localparam int DIV_Q_W     = 31;
  localparam int ROOT_K_W    = 17;
  localparam logic [ARC_W-1:0] ARC_MAX   = '1;
  localparam logic [LEN_W-1:0] LEN_OVER  = 33'h1_0000_0000;
  localparam logic [COMP_W-1:0] UNIT_ONE = 15'd16384;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LEN_A, S_LEN_AW, S_LEN_B, S_LEN_BW, S_LEN_R, S_LEN_RW,
    S_SEG,
    S_UV_NORM, S_UV_SA, S_UV_SAW, S_UV_SB, S_UV_SBW,
    S_UV_C2, S_UV_C2W, S_UV_DIV, S_UV_DIVW, S_UV_RT, S_UV_RTW,
    S_UV_END,
    S_EMIT
  } pna_state_t;

  typedef enum logic [1:0] {
    PASS_SEG,
    PASS_VERT,
    PASS_FIN
  } pna_pass_t;

endpackage
`default_nettype wire

/* hw/rtl/pna_point_if.sv */
// ----------------------------------------------------------------------------
// pna_point_if: vertex input channel
// Carries one polyline vertex per transfer with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none
interface pna_point_if #(
  parameter int COORD_WIDTH = pna_pkg::COORD_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic                          last_point;

  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface
`default_nettype wire

/* hw/rtl/pna_result_if.sv */
// ----------------------------------------------------------------------------
// pna_result_if: vertex result channel
// Carries one vertex normal and arc length per transfer.
// ----------------------------------------------------------------------------
`default_nettype none
interface pna_result_if;
  logic                              valid;
  logic                              ready;
  logic signed [pna_pkg::UNIT_W-1:0] normal_x;
  logic signed [pna_pkg::UNIT_W-1:0] normal_y;
  logic        [pna_pkg::ARC_W-1:0]  arc_length;
  logic                              final_vertex;

  modport source (output valid, normal_x, normal_y, arc_length, final_vertex, input ready);
  modport sink   (input valid, normal_x, normal_y, arc_length, final_vertex, output ready);
endinterface
`default_nettype wire

/* hw/rtl/pna_sqr.sv */
// ----------------------------------------------------------------------------
// pna_sqr: bit-serial square and accumulate
// Adds v*v to a preset value, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module pna_sqr #(
  parameter int VW    = 25,
  parameter int ACC_W = 2 * VW + 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [VW-1:0]    v,
  input  wire logic [ACC_W-1:0] init,
  output logic                  done,
  output logic [ACC_W-1:0]      acc
);
  localparam int CW = $clog2(VW + 1);

  logic [ACC_W-1:0] mcand;
  logic [VW-1:0]    mplier;
  logic [CW-1:0]    cnt;
  logic             busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        acc    <= init;
        mcand  <= ACC_W'(v);
        mplier <= v;
        cnt    <= CW'(VW);
      end else if (busy) begin
        if (mplier[0]) begin
          acc <= acc + mcand;
        end
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        cnt    <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/pna_sqrt.sv */
// ----------------------------------------------------------------------------
// pna_sqrt: digit-serial integer square root
// Produces the floor root and remainder, two radicand bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module pna_sqrt #(
  parameter int SQ_W = 52,
  parameter int RW   = SQ_W / 2
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [SQ_W-1:0] n,
  output logic                 done,
  output logic [RW-1:0]        root,
  output logic [RW:0]          rem_out
);
  localparam int CW = $clog2(RW + 1);

  logic [SQ_W-1:0] nsh;
  logic [RW+1:0]   rem;
  logic [RW+1:0]   rem_sh;
  logic [RW+1:0]   trial;
  logic [CW-1:0]   cnt;
  logic            busy;

  assign rem_sh  = {rem[RW-1:0], nsh[SQ_W-1 -: 2]};
  assign trial   = {root, 2'b01};
  assign rem_out = rem[RW:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        nsh  <= n;
        rem  <= '0;
        root <= '0;
        cnt  <= CW'(RW);
      end else if (busy) begin
        nsh <= nsh << 2;
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[RW-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[RW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/pna_div.sv */
// ----------------------------------------------------------------------------
// pna_div: bit-serial restoring divider
// Divides the scaled squared component by the squared magnitude, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module pna_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [pna_pkg::DIV_NUM_W-1:0] num,
  input  wire logic [pna_pkg::SUMS_W-1:0]    den,
  output logic                               done,
  output logic [pna_pkg::DIV_Q_W-1:0]        quo
);
  localparam int NW = pna_pkg::DIV_NUM_W;
  localparam int DW = pna_pkg::SUMS_W;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] nsh;
  logic [DW:0]   rem;
  logic [DW:0]   rem_sh;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          qbit;

  assign rem_sh = {rem[DW-1:0], nsh[NW-1]};
  assign qbit   = (rem_sh >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        nsh  <= num;
        rem  <= '0;
        quo  <= '0;
        cnt  <= CW'(NW);
      end else if (busy) begin
        nsh <= nsh << 1;
        rem <= qbit ? rem_sh - {1'b0, den} : rem_sh;
        quo <= {quo[pna_pkg::DIV_Q_W-2:0], qbit};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/polyline_normal_arclength.sv */
// ----------------------------------------------------------------------------
// polyline_normal_arclength: polyline vertex normals and arc length
// Vertices arrive on the point channel, one per transfer, last_point set on
// the final vertex of a polyline. Each vertex yields one result on the result
// channel: its unit normal in Q1.14 and its cumulative arc length in Q32.0.
// Results lag one vertex; the final vertex releases two results, the second
// with final_vertex set, after which a new polyline begins. A first vertex
// marked last gives one zero result at once.
// A vertex is taken only while the sequencer is idle. Its work runs through a
// bit-serial squarer, a bit-serial restoring divider and a two-bit-per-cycle
// root unit, with VW = max(COORD_WIDTH+1, 18) and RW = VW+1: first the segment
// length, then each unit vector after up to VW-16 normalizing shifts, two unit
// vectors per vertex and three on the final one. The result register holds one
// result; if the receiver stalls, the block finishes the next result and waits
// before loading it. Reset is synchronous and returns the block to the start
// of a polyline.
// ----------------------------------------------------------------------------
`default_nettype none
module polyline_normal_arclength #(
  parameter int COORD_WIDTH = pna_pkg::COORD_WIDTH
) (
  input wire logic     clk,
  input wire logic     rst,
  pna_point_if.sink    point,
  pna_result_if.source result
);
  localparam int W     = COORD_WIDTH;
  localparam int VW    = (W + 1 > 18) ? W + 1 : 18;
  localparam int ACC_W = 2 * VW + 1;
  localparam int SQ_W  = ACC_W + 1;
  localparam int RW    = SQ_W / 2;
  localparam int UW    = pna_pkg::UNIT_W;
  localparam int CMW   = pna_pkg::COMP_W;

  pna_pkg::pna_state_t state, state_next;
  pna_pkg::pna_pass_t  pass;

  logic signed [W-1:0]  prev_x, prev_y, cur_x, cur_y;
  logic signed [UW-1:0] snx, sny, ox, oy;
  logic [pna_pkg::ARC_W-1:0] pend, arc;
  logic                      started, last_r;
  logic signed [VW-1:0]      dx, dy;
  logic [pna_pkg::LEN_W-1:0] len;
  logic [VW-1:0]             ma, mb;
  logic                      neg_x, neg_y, comp;
  logic [pna_pkg::SUMS_W-1:0] s;
  logic [pna_pkg::SQC_W-1:0]  c2;
  logic [CMW-1:0]            mx, my;
  logic signed [UW-1:0]      e_nx, e_ny;
  logic [pna_pkg::ARC_W-1:0] e_arc;
  logic                      e_fin;

  logic             sqr_start, sqr_done, sqrt_start, sqrt_done, div_start, div_done;
  logic [VW-1:0]    sqr_v;
  logic [ACC_W-1:0] sqr_init, sqr_acc;
  logic [SQ_W-1:0]  sqrt_n;
  logic [RW-1:0]    sqrt_root;
  logic [RW:0]      sqrt_rem;
  logic [pna_pkg::DIV_Q_W-1:0] quo;

  logic                 accept, out_free, ovf;
  logic signed [VW-1:0] dx_new, dy_new;
  logic [pna_pkg::LEN_W-1:0] len_calc;
  logic [pna_pkg::ARC_W+1:0] arc_sum;
  logic [pna_pkg::ROOT_K_W-1:0] k_inc;
  logic signed [UW-1:0] ux, uy;
  logic signed [UW:0]   sum_x, sum_y;

  function automatic logic [VW-1:0] mag(input logic signed [VW-1:0] v);
    return v[VW-1] ? VW'(-v) : VW'(v);
  endfunction

  assign point.ready = (state == pna_pkg::S_IDLE);
  assign accept      = point.valid && point.ready;
  assign out_free    = !result.valid || result.ready;

  assign dx_new = $signed({{(VW-W){point.point_x[W-1]}}, point.point_x})
                - $signed({{(VW-W){prev_x[W-1]}}, prev_x});
  assign dy_new = $signed({{(VW-W){point.point_y[W-1]}}, point.point_y})
                - $signed({{(VW-W){prev_y[W-1]}}, prev_y});

  assign ovf      = |(sqr_acc >> 64);
  assign len_calc = pna_pkg::LEN_W'(sqrt_root)
                  + pna_pkg::LEN_W'(sqrt_rem > {1'b0, sqrt_root});
  assign arc_sum  = {2'b00, pend} + {1'b0, len};
  assign k_inc    = sqrt_root[pna_pkg::ROOT_K_W-1:0] + 1'b1;
  assign ux       = neg_x ? -$signed({1'b0, mx}) : $signed({1'b0, mx});
  assign uy       = neg_y ? -$signed({1'b0, my}) : $signed({1'b0, my});
  assign sum_x    = {snx[UW-1], snx} + {ux[UW-1], ux};
  assign sum_y    = {sny[UW-1], sny} + {uy[UW-1], uy};

  always_comb begin
    sqr_v    = ma;
    sqr_init = '0;
    case (state)
      pna_pkg::S_LEN_A: sqr_v = mag(dx);
      pna_pkg::S_LEN_B: begin
        sqr_v    = mag(dy);
        sqr_init = sqr_acc;
      end
      pna_pkg::S_UV_SB: begin
        sqr_v    = mb;
        sqr_init = sqr_acc;
      end
      pna_pkg::S_UV_C2: sqr_v = comp ? mb : ma;
      default: sqr_v = ma;
    endcase
    sqrt_n = (state == pna_pkg::S_UV_RT) ? SQ_W'(quo) : SQ_W'(sqr_acc);
  end

  always_comb begin
    state_next = state;
    sqr_start  = 1'b0;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    case (state)
      pna_pkg::S_IDLE: begin
        if (accept) begin
          if (!started) begin
            if (point.last_point) begin
              state_next = pna_pkg::S_EMIT;
            end
          end else begin
            state_next = pna_pkg::S_LEN_A;
          end
        end
      end
      pna_pkg::S_LEN_A: begin
        sqr_start  = 1'b1;
        state_next = pna_pkg::S_LEN_AW;
      end
      pna_pkg::S_LEN_AW: if (sqr_done) state_next = pna_pkg::S_LEN_B;
      pna_pkg::S_LEN_B: begin
        sqr_start  = 1'b1;
        state_next = pna_pkg::S_LEN_BW;
      end
      pna_pkg::S_LEN_BW: if (sqr_done) state_next = pna_pkg::S_LEN_R;
      pna_pkg::S_LEN_R: begin
        if (ovf) begin
          state_next = pna_pkg::S_SEG;
        end else begin
          sqrt_start = 1'b1;
          state_next = pna_pkg::S_LEN_RW;
        end
      end
      pna_pkg::S_LEN_RW: if (sqrt_done) state_next = pna_pkg::S_SEG;
      pna_pkg::S_SEG: state_next = pna_pkg::S_UV_NORM;
      pna_pkg::S_UV_NORM: begin
        if (ma[VW-1:pna_pkg::MAG_BITS] == '0 && mb[VW-1:pna_pkg::MAG_BITS] == '0) begin
          state_next = pna_pkg::S_UV_SA;
        end
      end
      pna_pkg::S_UV_SA: begin
        sqr_start  = 1'b1;
        state_next = pna_pkg::S_UV_SAW;
      end
      pna_pkg::S_UV_SAW: if (sqr_done) state_next = pna_pkg::S_UV_SB;
      pna_pkg::S_UV_SB: begin
        sqr_start  = 1'b1;
        state_next = pna_pkg::S_UV_SBW;
      end
      pna_pkg::S_UV_SBW: begin
        if (sqr_done) begin
          state_next = (sqr_acc == '0) ? pna_pkg::S_UV_END : pna_pkg::S_UV_C2;
        end
      end
      pna_pkg::S_UV_C2: begin
        sqr_start  = 1'b1;
        state_next = pna_pkg::S_UV_C2W;
      end
      pna_pkg::S_UV_C2W: if (sqr_done) state_next = pna_pkg::S_UV_DIV;
      pna_pkg::S_UV_DIV: begin
        div_start  = 1'b1;
        state_next = pna_pkg::S_UV_DIVW;
      end
      pna_pkg::S_UV_DIVW: if (div_done) state_next = pna_pkg::S_UV_RT;
      pna_pkg::S_UV_RT: begin
        sqrt_start = 1'b1;
        state_next = pna_pkg::S_UV_RTW;
      end
      pna_pkg::S_UV_RTW: begin
        if (sqrt_done) begin
          state_next = comp ? pna_pkg::S_UV_END : pna_pkg::S_UV_C2;
        end
      end
      pna_pkg::S_UV_END: begin
        state_next = (pass == pna_pkg::PASS_SEG) ? pna_pkg::S_UV_NORM : pna_pkg::S_EMIT;
      end
      pna_pkg::S_EMIT: begin
        if (out_free) begin
          state_next = (!e_fin && last_r) ? pna_pkg::S_UV_NORM : pna_pkg::S_IDLE;
        end
      end
      default: state_next = pna_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pna_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (state == pna_pkg::S_EMIT && out_free) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started      <= 1'b0;
      prev_x       <= '0;
      prev_y       <= '0;
      snx          <= '0;
      sny          <= '0;
      pend         <= '0;
      pass         <= pna_pkg::PASS_SEG;
    end else begin
      case (state)
        pna_pkg::S_IDLE: begin
          if (accept) begin
            cur_x  <= point.point_x;
            cur_y  <= point.point_y;
            last_r <= point.last_point;
            dx     <= dx_new;
            dy     <= dy_new;
            if (!started) begin
              if (point.last_point) begin
                e_nx  <= '0;
                e_ny  <= '0;
                e_arc <= '0;
                e_fin <= 1'b1;
              end else begin
                prev_x  <= point.point_x;
                prev_y  <= point.point_y;
                snx     <= '0;
                sny     <= '0;
                pend    <= '0;
                started <= 1'b1;
              end
            end
          end
        end
        pna_pkg::S_LEN_R: if (ovf) len <= pna_pkg::LEN_OVER;
        pna_pkg::S_LEN_RW: if (sqrt_done) len <= len_calc;
        pna_pkg::S_SEG: begin
          arc   <= (arc_sum > {2'b00, pna_pkg::ARC_MAX}) ? pna_pkg::ARC_MAX
                                                        : arc_sum[pna_pkg::ARC_W-1:0];
          pass  <= pna_pkg::PASS_SEG;
          ma    <= mag(dy);
          neg_x <= dy[VW-1];
          mb    <= mag(dx);
          neg_y <= !dx[VW-1];
        end
        pna_pkg::S_UV_NORM: begin
          if (ma[VW-1:pna_pkg::MAG_BITS] != '0 || mb[VW-1:pna_pkg::MAG_BITS] != '0) begin
            ma <= ma >> 1;
            mb <= mb >> 1;
          end
        end
        pna_pkg::S_UV_SBW: begin
          if (sqr_done) begin
            s    <= sqr_acc[pna_pkg::SUMS_W-1:0];
            comp <= 1'b0;
            if (sqr_acc == '0) begin
              mx <= '0;
              my <= '0;
            end
          end
        end
        pna_pkg::S_UV_C2W: if (sqr_done) c2 <= sqr_acc[pna_pkg::SQC_W-1:0];
        pna_pkg::S_UV_RTW: begin
          if (sqrt_done) begin
            if (comp) begin
              my <= k_inc[pna_pkg::COMP_W:1];
            end else begin
              mx   <= k_inc[pna_pkg::COMP_W:1];
              comp <= 1'b1;
            end
          end
        end
        pna_pkg::S_UV_END: begin
          case (pass)
            pna_pkg::PASS_SEG: begin
              ox    <= ux;
              oy    <= uy;
              pass  <= pna_pkg::PASS_VERT;
              ma    <= mag($signed({{(VW-UW-1){sum_x[UW]}}, sum_x}));
              neg_x <= sum_x[UW];
              mb    <= mag($signed({{(VW-UW-1){sum_y[UW]}}, sum_y}));
              neg_y <= sum_y[UW];
            end
            pna_pkg::PASS_VERT: begin
              e_nx  <= ux;
              e_ny  <= uy;
              e_arc <= pend;
              e_fin <= 1'b0;
            end
            default: begin
              e_nx  <= ux;
              e_ny  <= uy;
              e_arc <= arc;
              e_fin <= 1'b1;
            end
          endcase
        end
        pna_pkg::S_EMIT: begin
          if (out_free) begin
            result.normal_x     <= e_nx;
            result.normal_y     <= e_ny;
            result.arc_length   <= e_arc;
            result.final_vertex <= e_fin;
            if (e_fin) begin
              started <= 1'b0;
              prev_x  <= '0;
              prev_y  <= '0;
              snx     <= '0;
              sny     <= '0;
              pend    <= '0;
            end else if (last_r) begin
              pass  <= pna_pkg::PASS_FIN;
              ma    <= mag($signed({{(VW-UW){ox[UW-1]}}, ox}));
              neg_x <= ox[UW-1];
              mb    <= mag($signed({{(VW-UW){oy[UW-1]}}, oy}));
              neg_y <= oy[UW-1];
            end else begin
              prev_x <= cur_x;
              prev_y <= cur_y;
              snx    <= ox;
              sny    <= oy;
              pend   <= arc;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  pna_sqr #(.VW(VW), .ACC_W(ACC_W)) u_sqr (
    .clk   (clk),
    .rst   (rst),
    .start (sqr_start),
    .v     (sqr_v),
    .init  (sqr_init),
    .done  (sqr_done),
    .acc   (sqr_acc)
  );

  pna_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({c2, pna_pkg::FRAC_SHIFT'(0)}),
    .den   (s),
    .done  (div_done),
    .quo   (quo)
  );

  pna_sqrt #(.SQ_W(SQ_W), .RW(RW)) u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (sqrt_start),
    .n       (sqrt_n),
    .done    (sqrt_done),
    .root    (sqrt_root),
    .rem_out (sqrt_rem)
  );

  a_busy_has_run: assert property (@(posedge clk) disable iff (rst)
    (state != pna_pkg::S_IDLE) |-> (started || (state == pna_pkg::S_EMIT && e_fin)))
    else $error("sequencer busy outside a polyline");

  a_norm_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == pna_pkg::S_UV_SA) |->
      (ma[VW-1:pna_pkg::MAG_BITS] == '0 && mb[VW-1:pna_pkg::MAG_BITS] == '0))
    else $error("magnitude not normalized before squaring");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    (state == pna_pkg::S_UV_END) |-> (mx <= pna_pkg::UNIT_ONE && my <= pna_pkg::UNIT_ONE))
    else $error("unit component above one");

endmodule
`default_nettype wire
